// File: sv/ncvl_pkg.sv
`default_nettype none

package ncvl_pkg;

    localparam int MAX_CENTERS_DEF = 64;
    localparam int COORD_BITS_DEF  = 12;

    localparam int CNT_REG_W = 7;
    localparam int IDX_W     = 6;
    localparam int POS_W     = 12;
    localparam int LABEL_W   = 16;
    localparam int DIST_W    = 25;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   entry_index;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [LABEL_W-1:0] region_label;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   nearest_index;
        logic [LABEL_W-1:0] nearest_label;
        logic [DIST_W-1:0]  best_distance;
        logic               found;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/ncvl_center_mem.sv
`default_nettype none

// Center table: one write port, one read port with registered read data.
// The read is tagged with a valid bit and the entry index so that the
// distance pipeline knows what it is working on.
module ncvl_center_mem #(
    parameter int MAX_CENTERS = ncvl_pkg::MAX_CENTERS_DEF,
    parameter int COORD_BITS  = ncvl_pkg::COORD_BITS_DEF,
    parameter int ADDR_W      = $clog2(MAX_CENTERS)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic [ADDR_W-1:0]            i_waddr,
    input  wire logic [COORD_BITS-1:0]        i_wx,
    input  wire logic [COORD_BITS-1:0]        i_wy,
    input  wire logic [ncvl_pkg::LABEL_W-1:0] i_wlabel,
    input  wire logic                         i_re,
    input  wire logic [ADDR_W-1:0]            i_raddr,
    output logic                              o_vld,
    output logic [ADDR_W-1:0]                 o_idx,
    output logic [COORD_BITS-1:0]             o_x,
    output logic [COORD_BITS-1:0]             o_y,
    output logic [ncvl_pkg::LABEL_W-1:0]      o_label
);
    import ncvl_pkg::*;

    logic [COORD_BITS-1:0] r_mem_x   [MAX_CENTERS];
    logic [COORD_BITS-1:0] r_mem_y   [MAX_CENTERS];
    logic [LABEL_W-1:0]    r_mem_lab [MAX_CENTERS];

    logic                  r_vld;
    logic [ADDR_W-1:0]     r_idx;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [LABEL_W-1:0]    r_lab;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr]   <= i_wx;
            r_mem_y[i_waddr]   <= i_wy;
            r_mem_lab[i_waddr] <= i_wlabel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= r_mem_x[i_raddr];
        r_y   <= r_mem_y[i_raddr];
        r_lab <= r_mem_lab[i_raddr];
        r_idx <= i_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_re;
        end
    end

    assign o_vld   = r_vld;
    assign o_idx   = r_idx;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_label = r_lab;

endmodule

`default_nettype wire

// File: sv/ncvl_dist_unit.sv
`default_nettype none

// Shared squared-distance unit, three stages: absolute differences,
// squares, then a saturating sum. One center enters per cycle.
module ncvl_dist_unit #(
    parameter int COORD_BITS = ncvl_pkg::COORD_BITS_DEF,
    parameter int ADDR_W     = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    input  wire logic [ADDR_W-1:0]            i_idx,
    input  wire logic [ncvl_pkg::LABEL_W-1:0] i_label,
    input  wire logic [COORD_BITS-1:0]        i_cx,
    input  wire logic [COORD_BITS-1:0]        i_cy,
    input  wire logic [COORD_BITS-1:0]        i_px,
    input  wire logic [COORD_BITS-1:0]        i_py,
    output logic                              o_vld,
    output logic [ADDR_W-1:0]                 o_idx,
    output logic [ncvl_pkg::LABEL_W-1:0]      o_label,
    output logic [ncvl_pkg::DIST_W-1:0]       o_dist
);
    import ncvl_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    logic [COORD_BITS-1:0] dx, dy;
    logic [SQ_W-1:0]       sq_x, sq_y;
    logic [EXT_W-1:0]      sum_ext;

    logic                  r_v2, r_v3, r_v4;
    logic [ADDR_W-1:0]     r_idx2, r_idx3, r_idx4;
    logic [LABEL_W-1:0]    r_lab2, r_lab3, r_lab4;
    logic [COORD_BITS-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]       r_sx, r_sy;
    logic [DIST_W-1:0]     r_dist;

    assign dx      = (i_px >= i_cx) ? (i_px - i_cx) : (i_cx - i_px);
    assign dy      = (i_py >= i_cy) ? (i_py - i_cy) : (i_cy - i_py);
    assign sq_x    = SQ_W'(r_dx) * SQ_W'(r_dx);
    assign sq_y    = SQ_W'(r_dy) * SQ_W'(r_dy);
    assign sum_ext = EXT_W'(SUM_W'(r_sx) + SUM_W'(r_sy));

    always_ff @(posedge i_clk) begin
        r_dx   <= dx;
        r_dy   <= dy;
        r_idx2 <= i_idx;
        r_lab2 <= i_label;
        r_sx   <= sq_x;
        r_sy   <= sq_y;
        r_idx3 <= r_idx2;
        r_lab3 <= r_lab2;
        r_idx4 <= r_idx3;
        r_lab4 <= r_lab3;
        // Large coordinate widths can exceed the result range; clamp to all ones.
        if (sum_ext > EXT_W'(DIST_MAX)) begin
            r_dist <= DIST_MAX;
        end else begin
            r_dist <= DIST_W'(sum_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_vld;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_vld   = r_v4;
    assign o_idx   = r_idx4;
    assign o_label = r_lab4;
    assign o_dist  = r_dist;

endmodule

`default_nettype wire

// File: sv/nearest_center_voronoi_labeler_core.sv
// Nearest-center labeler. A table of up to MAX_CENTERS centers (x, y, label)
// is filled by load transactions on the input channel (func = load). A query
// transaction (func = query) carries a pixel; the block scans entries
// 0 .. center_count-1 and returns one result transaction with the index and
// label of the closest center (lowest index on ties), the squared distance
// and a found flag. With no center searched, found is 0, index and label are
// 0 and the distance is all ones. The user must write center_count through
// i_cfg_we / i_cfg_wdata while the block is idle; the block does not enforce it.
//
// A load does not leave the idle state, so the block is ready again at once.
// A query with N > 0 searched centers holds ready low while it makes N table
// reads, one per cycle, each through the registered table port and the
// three-stage distance unit, and until the best match moves into the output
// register. So a new query is taken only once the last one is done. A query
// that searches nothing goes straight to that last step.
//
// The output register parts the two channels: a new transaction is accepted
// while a result still waits. If the receiver stalls, a finished query waits
// in its final state until the output register frees. Reset clears
// center_count to 0 and empties both channels; the table has no reset value.
`default_nettype none

module nearest_center_voronoi_labeler_core #(
    parameter int MAX_CENTERS = ncvl_pkg::MAX_CENTERS_DEF,
    parameter int COORD_BITS  = ncvl_pkg::COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ncvl_pkg::CNT_REG_W-1:0] i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire ncvl_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output ncvl_pkg::t_out_item                 o_out_data
);
    import ncvl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CENTERS);
    localparam int CNT_W  = $clog2(MAX_CENTERS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CNT_REG_W-1:0]  r_center_count;
    logic [CNT_W-1:0]      r_limit;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_px, r_py;

    logic                  r_any;
    logic [DIST_W-1:0]     r_best;
    logic [ADDR_W-1:0]     r_best_idx;
    logic [LABEL_W-1:0]    r_best_label;

    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic                  in_accept, is_query, wr_en, issue, last_cmp, better, out_free;
    logic                  rd_vld, dist_vld;
    logic [ADDR_W-1:0]     rd_idx, dist_idx;
    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic [LABEL_W-1:0]    rd_label, dist_label;
    logic [DIST_W-1:0]     cand_dist;

    assign in_accept = i_in_valid && o_in_ready;
    assign is_query  = (i_in_data.func == FUNC_QUERY);
    assign wr_en     = in_accept && (i_in_data.func == FUNC_LOAD)
                       && (32'(i_in_data.entry_index) < MAX_CENTERS);
    assign issue     = (r_state == S_SCAN) && (r_cnt != r_limit);
    assign last_cmp  = dist_vld && (dist_idx == ADDR_W'(r_limit - CNT_W'(1)));
    assign better    = dist_vld && (!r_any || (cand_dist < r_best));
    assign out_free  = !r_out_valid || i_out_ready;

    ncvl_center_mem #(
        .MAX_CENTERS (MAX_CENTERS),
        .COORD_BITS  (COORD_BITS),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (wr_en),
        .i_waddr  (ADDR_W'(i_in_data.entry_index)),
        .i_wx     (COORD_BITS'(i_in_data.pos_x)),
        .i_wy     (COORD_BITS'(i_in_data.pos_y)),
        .i_wlabel (i_in_data.region_label),
        .i_re     (issue),
        .i_raddr  (r_cnt[ADDR_W-1:0]),
        .o_vld    (rd_vld),
        .o_idx    (rd_idx),
        .o_x      (rd_x),
        .o_y      (rd_y),
        .o_label  (rd_label)
    );

    ncvl_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rd_vld),
        .i_idx   (rd_idx),
        .i_label (rd_label),
        .i_cx    (rd_x),
        .i_cy    (rd_y),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_vld   (dist_vld),
        .o_idx   (dist_idx),
        .o_label (dist_label),
        .o_dist  (cand_dist)
    );

    // An empty search goes straight to the final state with the running minimum
    // as the query set it up, which already forms the "none" result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && is_query) begin
                    n_state = (32'(r_center_count) == 0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_cmp) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_center_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_center_count <= i_cfg_wdata;
            end
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan bookkeeping and the running minimum. Strict less-than keeps the
    // lowest index on equal distances because entries arrive in order.
    always_ff @(posedge i_clk) begin
        if (in_accept && is_query) begin
            r_px         <= COORD_BITS'(i_in_data.pos_x);
            r_py         <= COORD_BITS'(i_in_data.pos_y);
            r_cnt        <= '0;
            r_limit      <= (32'(r_center_count) > MAX_CENTERS) ? CNT_W'(MAX_CENTERS)
                                                                 : CNT_W'(r_center_count);
            r_any        <= 1'b0;
            r_best       <= DIST_MAX;
            r_best_idx   <= '0;
            r_best_label <= '0;
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (better) begin
                r_any        <= 1'b1;
                r_best       <= cand_dist;
                r_best_idx   <= dist_idx;
                r_best_label <= dist_label;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && out_free) begin
            r_out_data.nearest_index <= IDX_W'(r_best_idx);
            r_out_data.nearest_label <= r_best_label;
            r_out_data.best_distance <= r_best;
            r_out_data.found         <= r_any;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: sv/ncvl_checker.sv
`default_nettype none

module ncvl_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire ncvl_pkg::t_in_item             i_in_data,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire ncvl_pkg::t_out_item            o_out_data
);
    import ncvl_pkg::*;

    logic in_accept;
    assign in_accept = i_in_valid && o_in_ready;

    // A query takes the block out of the idle state, so input ready drops once it is accepted.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_data.func == FUNC_QUERY)) |=> !o_in_ready)
        else $error("input ready stayed high after a query transaction");

    // A load completes in its own cycle.
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_data.func == FUNC_LOAD)) |=> o_in_ready)
        else $error("input ready dropped after a load transaction");

    // An empty search reports the fixed "none" result.
    a_none_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        ((o_out_data.best_distance == DIST_MAX) && (o_out_data.nearest_index == '0)
         && (o_out_data.nearest_label == '0)))
        else $error("result without a center is not the none result");

    // A fresh result only comes out of a running query.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or vanished");

endmodule

bind nearest_center_voronoi_labeler_core ncvl_checker u_ncvl_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
`default_nettype none

// Testbench for the nearest-center labeler core.
//
// The bench keeps its own copy of the center table and of center_count. Each
// accepted load transaction updates that copy. Each accepted query transaction
// is scored against the copy at that moment, and the expected result is
// queued. A checker process pops the queue for every result transaction and
// compares it field by field.
//
// A query must never search a table entry that was never written. For that
// reason the bench tracks which entries hold a center. Before any query can
// run under a new center_count, it loads every unwritten entry below that
// count.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ncvl_pkg::*;

    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int RANDOM_ITEMS = 1600;
    // A load does not hold the block up. Idle cycles after the last result let
    // the block go quiet before center_count may change.
    localparam int LOAD_SETTLE  = 8;
    // At the end, allow a full scan plus the pipeline, so that a stray result
    // would still show up.
    localparam int END_SETTLE   = MAX_CENTERS_DEF + 16;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CNT_REG_W-1:0] cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;

    // This is the bench's own view of the block's state.
    logic [POS_W-1:0]     center_x     [MAX_CENTERS_DEF];
    logic [POS_W-1:0]     center_y     [MAX_CENTERS_DEF];
    logic [LABEL_W-1:0]   center_label [MAX_CENTERS_DEF];
    bit                   center_loaded[MAX_CENTERS_DEF];
    logic [CNT_REG_W-1:0] search_count = '0;

    t_out_item            expected_nearest[$];

    int unsigned          failures     = 0;
    int unsigned          items_sent   = 0;
    int unsigned          cycles       = 0;

    // These are the receiver controls. rx_hold_left forces a long hold-off.
    // rx_steady keeps the receiver ready while no hold-off or stall counts down.
    int unsigned          rx_hold_left  = 0;
    int unsigned          rx_stall_left = 0;
    bit                   rx_steady     = 1'b0;
    // When this is set, coordinates crowd into the corners, so that ties
    // and duplicate centers become common.
    bit                   clustered     = 1'b0;

    nearest_center_voronoi_labeler_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // This is a hard limit on run length. It is far above the slowest
    // legal run.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Most gaps are zero or short. A few are long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // The receiver changes ready on the falling edge. A forced hold-off takes
    // priority over everything else. After that come random stalls, unless
    // the current phase runs with a steady receiver.
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_stall_left > 0) begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_steady || $urandom_range(0, 3) != 0) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= 1'b0;
            rx_stall_left = pick_gap();
        end
    end

    // The predictor does a brute-force scan of the searched entries. It uses
    // exact squared distance, and the lowest index wins on a tie. A count
    // above the table size searches the whole table.
    function automatic t_out_item nearest_center(input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py);
        t_out_item res;
        int        span;
        int        best_idx;
        longint    dx;
        longint    dy;
        longint    sq_dist;
        longint    best;
        bit        any;
        span     = (search_count > MAX_CENTERS_DEF) ? MAX_CENTERS_DEF : int'(search_count);
        best     = longint'(DIST_MAX);
        best_idx = 0;
        any      = 1'b0;
        for (int i = 0; i < span; i++) begin
            dx      = (px >= center_x[i]) ? px - center_x[i] : center_x[i] - px;
            dy      = (py >= center_y[i]) ? py - center_y[i] : center_y[i] - py;
            sq_dist = dx * dx + dy * dy;
            if (sq_dist > longint'(DIST_MAX))
                sq_dist = longint'(DIST_MAX);
            if (!any || sq_dist < best) begin
                best     = sq_dist;
                best_idx = i;
                any      = 1'b1;
            end
        end
        res.found         = any;
        res.nearest_index = any ? IDX_W'(best_idx) : '0;
        res.nearest_label = any ? center_label[best_idx] : '0;
        res.best_distance = best[DIST_W-1:0];
        return res;
    endfunction

    // Apply one accepted transaction to the bench's state.
    task automatic apply_item(input t_in_item it);
        if (it.func == FUNC_LOAD) begin
            center_x[it.entry_index]      = it.pos_x;
            center_y[it.entry_index]      = it.pos_y;
            center_label[it.entry_index]  = it.region_label;
            center_loaded[it.entry_index] = 1'b1;
        end else begin
            expected_nearest = {expected_nearest, nearest_center(it.pos_x, it.pos_y)};
        end
    endtask

    function automatic t_in_item make_load(input int unsigned idx,
                                           input int unsigned x,
                                           input int unsigned y,
                                           input int unsigned label);
        t_in_item it;
        it.func         = FUNC_LOAD;
        it.entry_index  = IDX_W'(idx);
        it.pos_x        = POS_W'(x);
        it.pos_y        = POS_W'(y);
        it.region_label = LABEL_W'(label);
        return it;
    endfunction

    // A query ignores entry_index and region_label, so those fields get
    // random values.
    function automatic t_in_item make_query(input int unsigned x, input int unsigned y);
        t_in_item it;
        it.func         = FUNC_QUERY;
        it.entry_index  = IDX_W'($urandom_range(0, MAX_CENTERS_DEF - 1));
        it.pos_x        = POS_W'(x);
        it.pos_y        = POS_W'(y);
        it.region_label = LABEL_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic int unsigned rand_coord();
        if (!clustered)
            return $urandom_range(0, 4095);
        else if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 7);
        else
            return $urandom_range(4088, 4095);
    endfunction

    function automatic t_in_item rand_item();
        if ($urandom_range(0, 99) < 60)
            return make_query(rand_coord(), rand_coord());
        else
            return make_load($urandom_range(0, MAX_CENTERS_DEF - 1), rand_coord(),
                             rand_coord(), $urandom_range(0, 65535));
    endfunction

    // Send one transaction after a gap of idle cycles. Valid is left high on
    // return. The caller either sends the next transaction on the following
    // falling edge or calls drain, which lowers valid.
    task automatic send_item(input t_in_item it, input int unsigned gap);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        apply_item(it);
        items_sent++;
    endtask

    // Stop sending, wait for every queued result, and then let the block go
    // quiet.
    task automatic drain(input int unsigned settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_nearest.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // center_count may change only while the block is idle.
    task automatic write_count(input int unsigned value);
        drain(LOAD_SETTLE);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_REG_W'(value);
        @(posedge clk);
        search_count = CNT_REG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Make sure that every entry the current count searches holds a center.
    task automatic load_missing_centers(input int unsigned gap_max);
        int unsigned span;
        span = (search_count > MAX_CENTERS_DEF) ? MAX_CENTERS_DEF : search_count;
        for (int unsigned i = 0; i < span; i++)
            if (!center_loaded[i])
                send_item(make_load(i, rand_coord(), rand_coord(), $urandom_range(0, 65535)),
                          gap_max == 0 ? 0 : pick_gap());
    endtask

    // This process checks every result transaction against the oldest
    // prediction.
    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_nearest.size() == 0) begin
                $display("%0t: result with no query pending: index %0d label %0d distance %0d found %0d",
                         $time, out_data.nearest_index, out_data.nearest_label,
                         out_data.best_distance, out_data.found);
                failures++;
            end else begin
                want = expected_nearest.pop_front();
                check_field("nearest_index", want.nearest_index, out_data.nearest_index);
                check_field("nearest_label", want.nearest_label, out_data.nearest_label);
                check_field("best_distance", want.best_distance, out_data.best_distance);
                check_field("found", want.found, out_data.found);
            end
        end
    end

    // After reset, center_count is 0. These queries search nothing and must
    // report "not found" with the maximum distance.
    task automatic test_empty_search();
        send_item(make_query(0, 0), 0);
        send_item(make_query(4095, 4095), 0);
        drain(LOAD_SETTLE);
    endtask

    // This test uses hand-placed centers. It covers corner coordinates, a
    // duplicate center, an exact tie between different centers, and the
    // largest distance the coordinate range allows.
    task automatic test_directed_nearest();
        send_item(make_load(0, 0, 0, 16'hFFFF), 0);
        send_item(make_load(1, 4095, 4095, 16'h0000), 0);
        send_item(make_load(2, 2, 0, 16'h1234), 1);
        send_item(make_load(3, 0, 0, 16'h5555), 0);
        send_item(make_load(63, 4095, 0, 16'hA5A5), 0);
        write_count(4);
        // Entry 3 duplicates entry 0, so the lower index must win.
        send_item(make_query(0, 0), 0);
        send_item(make_query(4095, 4095), 0);
        // Entries 0, 2 and 3 are all at distance 1 from this pixel.
        send_item(make_query(1, 0), 2);
        send_item(make_query(2, 0), 0);
        send_item(make_query(4095, 0), 0);
        // Entries 0, 1 and 3 tie here at 4095 squared, and entry 2 is farther.
        send_item(make_query(0, 4095), 0);
        write_count(1);
        // This is the opposite corner from the only searched center, which
        // gives the largest distance possible.
        send_item(make_query(4095, 4095), 0);
        write_count(0);
        send_item(make_query(2048, 2048), 0);
        drain(LOAD_SETTLE);
    endtask

    // Fill the whole table. Then search it with counts at and above the
    // table size. Counts above the table size must search exactly the whole
    // table.
    task automatic test_full_scan();
        int unsigned counts[3];
        counts = '{MAX_CENTERS_DEF, MAX_CENTERS_DEF + 1, (1 << CNT_REG_W) - 1};
        for (int unsigned i = 0; i < MAX_CENTERS_DEF; i++)
            send_item(make_load(i, rand_coord(), rand_coord(), $urandom_range(0, 65535)),
                      pick_gap());
        foreach (counts[k]) begin
            write_count(counts[k]);
            repeat (4)
                send_item(make_query(rand_coord(), rand_coord()), pick_gap());
        end
        drain(LOAD_SETTLE);
    endtask

    // The receiver holds off for a long stretch while queries keep coming.
    // The output register and the finished scan behind it fill up, so input
    // ready must drop until the receiver lets go.
    task automatic test_backpressure();
        write_count(2);
        rx_hold_left = 300;
        repeat (24)
            send_item(make_query(rand_coord(), rand_coord()), 0);
        drain(LOAD_SETTLE);
    endtask

    // Random phases. Each phase picks a center count, mostly small ones and
    // a few at or past the table size. It then loads any entries that the
    // count needs and runs a mix of loads and queries. Some phases crowd the
    // coordinates to force ties. Some phases run with no idle cycles on
    // either side.
    task automatic test_random_phases();
        int unsigned goal;
        int unsigned count;
        int unsigned pick;
        bit          quiet;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                count = 0;
            else if (pick == 1)
                count = $urandom_range(MAX_CENTERS_DEF, (1 << CNT_REG_W) - 1);
            else if (pick < 4)
                count = $urandom_range(9, MAX_CENTERS_DEF - 1);
            else
                count = $urandom_range(1, 8);
            quiet     = ($urandom_range(0, 4) == 0);
            clustered = ($urandom_range(0, 3) == 0);
            write_count(count);
            rx_steady = quiet;
            load_missing_centers(quiet ? 0 : 1);
            repeat ($urandom_range(40, 160))
                send_item(rand_item(), quiet ? 0 : pick_gap());
        end
        rx_steady = 1'b0;
        clustered = 1'b0;
        drain(LOAD_SETTLE);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_search();
        test_directed_nearest();
        test_full_scan();
        test_backpressure();
        test_random_phases();

        drain(END_SETTLE);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
